@@ rtl/prrd_pkg.sv @@
package prrd_pkg;

    localparam int IDX_BITS    = 16;
    localparam int MAP_DEPTH   = 1 << IDX_BITS;
    localparam int EPOCH_BITS  = 8;
    localparam int PIX_BITS    = 24;
    localparam int DIM_BITS    = 12;
    localparam int SLOT_BITS   = 16;
    localparam int WORD_BITS   = 64;
    localparam int STATUS_BITS = 3;
    localparam int CNT_BITS    = $clog2(PIX_BITS);
    localparam int QDEPTH      = 2;
    localparam int QPTR_BITS   = $clog2(QDEPTH);
    localparam int QCNT_BITS   = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 12'd480;

    localparam logic [3:0] FLAG_MAX = 4'd1;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK         = 3'd0,
        ST_END        = 3'd1,
        ST_BAD_PIXEL  = 3'd2,
        ST_BAD_FLAG_A = 3'd3,
        ST_BAD_FLAG_B = 3'd4,
        ST_REUSE_A    = 3'd5,
        ST_REUSE_B    = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_CHECK
    } t_back_state;

    typedef struct packed {
        logic                 is_end;
        logic [PIX_BITS-1:0]  pix_m1;
        t_status              flag_status;
        logic                 has_a;
        logic [SLOT_BITS-1:0] idx_a;
        logic                 has_b;
        logic [SLOT_BITS-1:0] idx_b;
    } t_rec;

endpackage

@@ rtl/prrd_ram.sv @@
module prrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/prrd_front.sv @@
module prrd_front (
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [prrd_pkg::WORD_BITS-1:0] i_record_word,
    input  logic                           i_clearing,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output prrd_pkg::t_rec                 o_q_rec
);
    import prrd_pkg::*;

    logic [PIX_BITS-1:0] pixnum;
    logic [3:0]          flag_a;
    logic [3:0]          flag_b;

    always_comb begin
        pixnum = i_record_word[63:40];
        flag_a = i_record_word[39:36];
        flag_b = i_record_word[19:16];

        o_q_rec.is_end = (pixnum == '0);
        o_q_rec.pix_m1 = pixnum - PIX_BITS'(1);
        if (flag_a > FLAG_MAX) begin
            o_q_rec.flag_status = ST_BAD_FLAG_A;
        end else if (flag_b > FLAG_MAX) begin
            o_q_rec.flag_status = ST_BAD_FLAG_B;
        end else begin
            o_q_rec.flag_status = ST_OK;
        end
        o_q_rec.has_a = flag_a[0];
        o_q_rec.idx_a = flag_a[0] ? i_record_word[35:20] : '0;
        o_q_rec.has_b = flag_b[0];
        o_q_rec.idx_b = flag_b[0] ? i_record_word[15:0] : '0;
    end

    assign o_in_stall = i_q_full | i_clearing;
    assign o_q_push   = i_in_valid & ~o_in_stall;

endmodule

@@ rtl/prrd_queue.sv @@
module prrd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  prrd_pkg::t_rec i_rec,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output prrd_pkg::t_rec o_rec
);
    import prrd_pkg::*;

    t_rec                 r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wptr;
    logic [QPTR_BITS-1:0] r_rptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QCNT_BITS-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_BITS'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : r_wptr + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : r_rptr + QPTR_BITS'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

    assign o_full  = (r_count == QCNT_BITS'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rptr];

endmodule

@@ rtl/prrd_back.sv @@
module prrd_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [prrd_pkg::DIM_BITS-1:0]    i_frame_width,
    input  logic [prrd_pkg::DIM_BITS-1:0]    i_frame_height,
    input  logic                             i_q_valid,
    input  prrd_pkg::t_rec                   i_q_rec,
    output logic                             o_q_pop,
    output logic                             o_clearing,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [prrd_pkg::STATUS_BITS-1:0] o_status,
    output logic [prrd_pkg::DIM_BITS-1:0]    o_pixel_row,
    output logic [prrd_pkg::DIM_BITS-1:0]    o_pixel_column,
    output logic                             o_has_slot_a,
    output logic [prrd_pkg::SLOT_BITS-1:0]   o_slot_a_index,
    output logic                             o_has_slot_b,
    output logic [prrd_pkg::SLOT_BITS-1:0]   o_slot_b_index
);
    import prrd_pkg::*;

    t_back_state           r_state;
    t_back_state           n_state;
    t_rec                  r_rec;
    logic [IDX_BITS-1:0]   r_addr;
    logic [EPOCH_BITS-1:0] r_epoch;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [DIM_BITS-1:0]   r_rem;
    logic [PIX_BITS-1:0]   r_quo;

    logic                  r_out_valid;
    t_status               r_status;
    logic [DIM_BITS-1:0]   r_row;
    logic [DIM_BITS-1:0]   r_col;
    logic                  r_has_a;
    logic [SLOT_BITS-1:0]  r_idx_a;
    logic                  r_has_b;
    logic [SLOT_BITS-1:0]  r_idx_b;

    logic [DIM_BITS:0]     div_shift;
    logic [DIM_BITS:0]     div_diff;
    logic                  div_ge;
    logic                  out_free;
    logic                  used_a;
    logic                  used_b;
    logic                  bad_pix;
    t_status               status;
    logic                  finish;

    logic                  we_a;
    logic                  we_b;
    logic [IDX_BITS-1:0]   addr_a;
    logic [IDX_BITS-1:0]   addr_b;
    logic [EPOCH_BITS-1:0] wdata;
    logic [EPOCH_BITS-1:0] rdata_a;
    logic [EPOCH_BITS-1:0] rdata_b;

    // restoring division step
    always_comb begin
        div_shift = {r_rem, r_quo[PIX_BITS-1]};
        div_diff  = div_shift - {1'b0, i_frame_width};
        div_ge    = (div_shift >= {1'b0, i_frame_width});
    end

    // entries hold the epoch in which they were marked
    always_comb begin
        out_free = ~r_out_valid | ~i_out_stall;
        used_a   = (rdata_a == r_epoch);
        used_b   = (rdata_b == r_epoch);
        bad_pix  = (i_frame_width == '0) | (r_quo >= PIX_BITS'(i_frame_height));
        if (r_rec.is_end) begin
            status = ST_END;
        end else if (bad_pix) begin
            status = ST_BAD_PIXEL;
        end else if (r_rec.flag_status != ST_OK) begin
            status = r_rec.flag_status;
        end else if (r_rec.has_a && used_a) begin
            status = ST_REUSE_A;
        end else if (r_rec.has_b && used_b) begin
            status = ST_REUSE_B;
        end else begin
            status = ST_OK;
        end
        finish = (r_state == S_CHECK) & out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_BITS'(PIX_BITS - 1)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (out_free) begin
                    n_state = (status != ST_OK && r_epoch == '1) ? S_CLEAR : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop    = 1'b0;
        o_clearing = 1'b0;
        we_a       = 1'b0;
        we_b       = 1'b0;
        addr_a     = r_rec.idx_a[IDX_BITS-1:0];
        addr_b     = r_rec.idx_b[IDX_BITS-1:0];
        wdata      = r_epoch;
        case (r_state)
            S_CLEAR: begin
                o_clearing = 1'b1;
                we_a       = 1'b1;
                we_b       = 1'b1;
                addr_a     = r_addr;
                addr_b     = r_addr;
                wdata      = '0;
            end
            S_IDLE: begin
                o_q_pop = i_q_valid;
            end
            S_CHECK: begin
                we_a = out_free & (status == ST_OK) & r_rec.has_a;
                we_b = out_free & (status == ST_OK) & r_rec.has_b;
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_epoch     <= EPOCH_BITS'(1);
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_addr <= r_addr + IDX_BITS'(1);
                if (r_addr == '1) begin
                    r_epoch <= EPOCH_BITS'(1);
                end
            end
            if (o_q_pop) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + CNT_BITS'(1);
            end
            if (finish && status != ST_OK) begin
                if (r_epoch == '1) begin
                    r_addr <= '0;
                end else begin
                    r_epoch <= r_epoch + EPOCH_BITS'(1);
                end
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rec <= i_q_rec;
            r_rem <= '0;
            r_quo <= i_q_rec.pix_m1;
        end else if (r_state == S_DIV) begin
            r_rem <= div_ge ? div_diff[DIM_BITS-1:0] : div_shift[DIM_BITS-1:0];
            r_quo <= {r_quo[PIX_BITS-2:0], div_ge};
        end
        if (finish) begin
            r_status <= status;
            if (status == ST_OK) begin
                r_row   <= r_quo[DIM_BITS-1:0];
                r_col   <= r_rem;
                r_has_a <= r_rec.has_a;
                r_idx_a <= r_rec.idx_a;
                r_has_b <= r_rec.has_b;
                r_idx_b <= r_rec.idx_b;
            end else begin
                r_row   <= '0;
                r_col   <= '0;
                r_has_a <= 1'b0;
                r_idx_a <= '0;
                r_has_b <= 1'b0;
                r_idx_b <= '0;
            end
        end
    end

    prrd_ram #(
        .WIDTH(EPOCH_BITS),
        .DEPTH(MAP_DEPTH)
    ) u_map_a (
        .i_clk  (i_clk),
        .i_we   (we_a),
        .i_addr (addr_a),
        .i_wdata(wdata),
        .o_rdata(rdata_a)
    );

    prrd_ram #(
        .WIDTH(EPOCH_BITS),
        .DEPTH(MAP_DEPTH)
    ) u_map_b (
        .i_clk  (i_clk),
        .i_we   (we_b),
        .i_addr (addr_b),
        .i_wdata(wdata),
        .o_rdata(rdata_b)
    );

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_pixel_row    = r_row;
    assign o_pixel_column = r_col;
    assign o_has_slot_a   = r_has_a;
    assign o_slot_a_index = r_idx_a;
    assign o_has_slot_b   = r_has_b;
    assign o_slot_b_index = r_idx_b;

endmodule

@@ rtl/pixel_replacement_record_decoder.sv @@
// Decodes one 8-byte pixel replacement record per request into a status, the row and
// column of the replacement pixel and the dead pixel indices of slots A and B. A record
// is classified on entry and waits in a two-entry queue; the back end then divides the
// pixel number minus one by frame_width one quotient bit a cycle, checks the slot maps
// and loads the result register before it takes the next record from the queue. Used
// slots are tracked in two 64K-entry epoch memories; an end of table or an error just
// advances the epoch. After reset, and after every 255th end of table or error, a
// clearing pass sweeps both memories while no record is accepted.
// Configuration writes are always ready and must only be made while the block is idle.
module pixel_replacement_record_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [prrd_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [prrd_pkg::DIM_BITS-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [prrd_pkg::WORD_BITS-1:0]    i_record_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [prrd_pkg::STATUS_BITS-1:0]  o_status,
    output logic [prrd_pkg::DIM_BITS-1:0]     o_pixel_row,
    output logic [prrd_pkg::DIM_BITS-1:0]     o_pixel_column,
    output logic                              o_has_slot_a,
    output logic [prrd_pkg::SLOT_BITS-1:0]    o_slot_a_index,
    output logic                              o_has_slot_b,
    output logic [prrd_pkg::SLOT_BITS-1:0]    o_slot_b_index
);
    import prrd_pkg::*;

    logic [DIM_BITS-1:0] r_frame_width;
    logic [DIM_BITS-1:0] r_frame_height;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_valid;
    t_rec push_rec;
    t_rec pop_rec;
    logic clearing;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: begin
                    r_frame_width <= r_frame_width;
                end
            endcase
        end
    end

    prrd_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_record_word(i_record_word),
        .i_clearing   (clearing),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_rec      (push_rec)
    );

    prrd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_rec  (push_rec),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_rec  (pop_rec)
    );

    prrd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_width (r_frame_width),
        .i_frame_height(r_frame_height),
        .i_q_valid     (q_valid),
        .i_q_rec       (pop_rec),
        .o_q_pop       (q_pop),
        .o_clearing    (clearing),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_pixel_row   (o_pixel_row),
        .o_pixel_column(o_pixel_column),
        .o_has_slot_a  (o_has_slot_a),
        .o_slot_a_index(o_slot_a_index),
        .o_has_slot_b  (o_has_slot_b),
        .o_slot_b_index(o_slot_b_index)
    );

endmodule
